>>> rtl/hj23_pkg.sv
// Shared types, constants and helper functions for the Halton jitter pipeline.
`default_nettype none
package hj23_pkg;

	localparam int FRAME_W        = 64;
	localparam int PHASE_W        = 11;
	localparam int MAX_PHASES     = 1024;
	localparam int REM_W          = $clog2(MAX_PHASES);
	localparam int DIV_W          = REM_W + 1;
	localparam int IDX_W          = DIV_W;
	localparam int BITS_PER_STAGE = 4;
	localparam int REM_STAGES     = FRAME_W / BITS_PER_STAGE;
	localparam int JIT_W          = 16;
	localparam int TERN_DIGITS    = 7;
	localparam int REV3_W         = 12;
	localparam int PHASE_RESET    = 16;

	localparam logic [JIT_W-1:0] HALF_Q16 = 16'h8000;

	localparam int               DIV3_SHIFT = 11;
	localparam logic [9:0]       DIV3_MUL   = 10'd683;
	localparam logic [20:0]      RECIP3_7   = 21'd1963862;
	localparam logic [11:0]      POW3_7     = 12'd2187;
	localparam int               PROD_W     = REV3_W + 21;
	localparam int               SCALED_W   = REV3_W + JIT_W;

	typedef struct packed {
		logic             valid;
		logic [REM_W-1:0] rem;
	} rem_beat_t;

	typedef struct packed {
		logic              valid;
		logic [JIT_W-1:0]  jx;
		logic [REV3_W-1:0] rev3;
	} tern_beat_t;

	typedef struct packed {
		logic [JIT_W-1:0] jx;
		logic [JIT_W-1:0] jy;
	} result_t;

	function automatic logic [DIV_W-1:0] clamp_phases(input logic [PHASE_W-1:0] v);
		logic [DIV_W-1:0] d;
		if (v == '0) begin
			d = DIV_W'(1);
		end else if (32'(v) > MAX_PHASES) begin
			d = DIV_W'(MAX_PHASES);
		end else begin
			d = DIV_W'(v);
		end
		return d;
	endfunction

	function automatic logic [REM_W-1:0] rem_step(input logic [REM_W-1:0] r, input logic b,
			input logic [DIV_W-1:0] d);
		logic [DIV_W-1:0] t;
		t = {r, b};
		return (t >= d) ? REM_W'(t - d) : REM_W'(t);
	endfunction

	function automatic logic [IDX_W-1:0] div3(input logic [IDX_W-1:0] v);
		logic [IDX_W+9:0] p;
		p = (IDX_W+10)'(v) * (IDX_W+10)'(DIV3_MUL);
		return IDX_W'(p >> DIV3_SHIFT);
	endfunction

	function automatic logic [JIT_W-1:0] base2_jitter(input logic [IDX_W-1:0] idx);
		logic [JIT_W-1:0] r;
		r = '0;
		for (int k = 0; k < IDX_W; k++) begin
			r[JIT_W-1-k] = idx[k];
		end
		return r ^ HALF_Q16;
	endfunction

endpackage
`default_nettype wire

>>> rtl/hj23_rem_pipe.sv
// Pipelined remainder of the frame number by the clamped phase count, four bits per stage.
`default_nettype none
module hj23_rem_pipe (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire logic                                   in_valid,
	input  wire logic [hj23_pkg::FRAME_W-1:0]           frame,
	input  wire logic [hj23_pkg::DIV_W-1:0]             div,
	output hj23_pkg::rem_beat_t                         rem_out
);

	logic                           vld_s [hj23_pkg::REM_STAGES];
	logic [hj23_pkg::REM_W-1:0]     rem_s [hj23_pkg::REM_STAGES];
	logic [hj23_pkg::FRAME_W-1:0]   frm_s [hj23_pkg::REM_STAGES-1];

	for (genvar k = 0; k < hj23_pkg::REM_STAGES; k++) begin : g_stage
		localparam int TOP = hj23_pkg::FRAME_W - 1 - k * hj23_pkg::BITS_PER_STAGE;
		logic                         v_in;
		logic [hj23_pkg::FRAME_W-1:0] f_in;
		logic [hj23_pkg::REM_W-1:0]   r_in;
		logic [hj23_pkg::REM_W-1:0]   r_nxt;

		if (k == 0) begin : g_head
			assign v_in = in_valid;
			assign f_in = frame;
			assign r_in = '0;
		end else begin : g_body
			assign v_in = vld_s[k-1];
			assign f_in = frm_s[k-1];
			assign r_in = rem_s[k-1];
		end

		always_comb begin
			r_nxt = r_in;
			for (int j = 0; j < hj23_pkg::BITS_PER_STAGE; j++) begin
				r_nxt = hj23_pkg::rem_step(r_nxt, f_in[TOP-j], div);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= r_nxt;
			end
		end

		if (k < hj23_pkg::REM_STAGES - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					frm_s[k] <= f_in;
				end
			end
		end
	end

	assign rem_out.valid = vld_s[hj23_pkg::REM_STAGES-1];
	assign rem_out.rem   = rem_s[hj23_pkg::REM_STAGES-1];

endmodule
`default_nettype wire

>>> rtl/hj23_tern_pipe.sv
// Phase index, base-2 jitter and base-3 digit reversal, one digit per stage.
`default_nettype none
module hj23_tern_pipe (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire hj23_pkg::rem_beat_t  rem_in,
	output hj23_pkg::tern_beat_t      tern_out
);

	logic                          vld_s [hj23_pkg::TERN_DIGITS];
	logic [hj23_pkg::IDX_W-1:0]    val_s [hj23_pkg::TERN_DIGITS-1];
	logic [hj23_pkg::REV3_W-1:0]   rev_s [hj23_pkg::TERN_DIGITS];
	logic [hj23_pkg::JIT_W-1:0]    jx_s  [hj23_pkg::TERN_DIGITS];

	for (genvar k = 0; k < hj23_pkg::TERN_DIGITS; k++) begin : g_stage
		logic                        v_in;
		logic [hj23_pkg::IDX_W-1:0]  val_in;
		logic [hj23_pkg::REV3_W-1:0] rev_in;
		logic [hj23_pkg::JIT_W-1:0]  jx_in;
		logic [hj23_pkg::IDX_W-1:0]  quo;
		logic [hj23_pkg::IDX_W-1:0]  dig;

		if (k == 0) begin : g_head
			assign v_in   = rem_in.valid;
			assign val_in = hj23_pkg::IDX_W'(rem_in.rem) + hj23_pkg::IDX_W'(1);
			assign rev_in = '0;
			assign jx_in  = hj23_pkg::base2_jitter(val_in);
		end else begin : g_body
			assign v_in   = vld_s[k-1];
			assign val_in = val_s[k-1];
			assign rev_in = rev_s[k-1];
			assign jx_in  = jx_s[k-1];
		end

		assign quo = hj23_pkg::div3(val_in);
		assign dig = val_in - (quo << 1) - quo;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rev_s[k] <= (rev_in << 1) + rev_in + hj23_pkg::REV3_W'(dig);
				jx_s[k]  <= jx_in;
			end
		end

		if (k < hj23_pkg::TERN_DIGITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					val_s[k] <= quo;
				end
			end
		end
	end

	assign tern_out.valid = vld_s[hj23_pkg::TERN_DIGITS-1];
	assign tern_out.jx    = jx_s[hj23_pkg::TERN_DIGITS-1];
	assign tern_out.rev3  = rev_s[hj23_pkg::TERN_DIGITS-1];

endmodule
`default_nettype wire

>>> rtl/hj23_scale_pipe.sv
// Scale of the reversed base-3 value to 16 fraction bits by reciprocal multiply and correction.
`default_nettype none
module hj23_scale_pipe (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire hj23_pkg::tern_beat_t tern_in,
	output logic                      res_valid,
	output hj23_pkg::result_t         res
);

	logic                            vld_s1;
	logic [hj23_pkg::REV3_W-1:0]     rev_s1;
	logic [hj23_pkg::JIT_W-1:0]      jx_s1;
	logic [hj23_pkg::JIT_W-1:0]      q0_s1;
	logic                            vld_s2;
	logic [hj23_pkg::REV3_W-1:0]     rev_s2;
	logic [hj23_pkg::JIT_W-1:0]      jx_s2;
	logic [hj23_pkg::JIT_W-1:0]      q0_s2;
	logic [hj23_pkg::SCALED_W-1:0]   back_s2;

	logic [hj23_pkg::PROD_W-1:0]     prod;
	logic [hj23_pkg::SCALED_W-1:0]   diff;
	logic [hj23_pkg::JIT_W-1:0]      jy;

	assign prod = hj23_pkg::PROD_W'(tern_in.rev3) * hj23_pkg::PROD_W'(hj23_pkg::RECIP3_7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= tern_in.valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rev_s1  <= tern_in.rev3;
			jx_s1   <= tern_in.jx;
			q0_s1   <= prod[2*hj23_pkg::JIT_W-1:hj23_pkg::JIT_W];
			rev_s2  <= rev_s1;
			jx_s2   <= jx_s1;
			q0_s2   <= q0_s1;
			back_s2 <= hj23_pkg::SCALED_W'(q0_s1) * hj23_pkg::SCALED_W'(hj23_pkg::POW3_7);
		end
	end

	assign diff = {rev_s2, hj23_pkg::JIT_W'(0)} - back_s2;
	assign jy   = (diff >= hj23_pkg::SCALED_W'(hj23_pkg::POW3_7)) ? q0_s2 + 1'b1 : q0_s2;

	assign res_valid = vld_s2;
	assign res.jx    = jx_s2;
	assign res.jy    = jy ^ hj23_pkg::HALF_Q16;

endmodule
`default_nettype wire

>>> rtl/halton_jitter_2_3_core.sv
// Top level of the Halton base-2/base-3 jitter generator.
//
//  channel   direction  handshake                 payload
//  input     in         in_valid / in_stall       frame
//  output    out        out_valid / out_stall     jitter_x, jitter_y
//  config    in         cfg_valid / cfg_ready     phase_len
//
// One beat per cycle while the output is not stalled; the path has 16 remainder stages,
// 7 base-3 digit stages, 2 scale stages and an output register.
// Reset sets the phase length to 16 and empties the pipeline.
// A stalled output beat parks in a skid register; in_stall is that register's
// full flag, so the pipeline freezes only when both output slots are taken.
`default_nettype none
module halton_jitter_2_3_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [hj23_pkg::FRAME_W-1:0]         frame,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [hj23_pkg::JIT_W-1:0]         jitter_x,
	output logic signed [hj23_pkg::JIT_W-1:0]         jitter_y,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [hj23_pkg::PHASE_W-1:0]         phase_len
);

	logic [hj23_pkg::DIV_W-1:0] div_q;
	logic                       en;
	hj23_pkg::rem_beat_t        rem_beat;
	hj23_pkg::tern_beat_t       tern_beat;
	logic                       res_valid;
	hj23_pkg::result_t          res;
	logic                       last_valid;
	logic                       out_valid_q;
	logic                       skid_full_q;
	hj23_pkg::result_t          out_res_q;
	hj23_pkg::result_t          skid_res_q;
	logic                       out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= hj23_pkg::DIV_W'(hj23_pkg::PHASE_RESET);
		end else if (cfg_valid && cfg_ready) begin
			div_q <= hj23_pkg::clamp_phases(phase_len);
		end
	end

	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;

	hj23_rem_pipe u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.frame    (frame),
		.div      (div_q),
		.rem_out  (rem_beat)
	);

	hj23_tern_pipe u_tern (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.rem_in   (rem_beat),
		.tern_out (tern_beat)
	);

	hj23_scale_pipe u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.tern_in   (tern_beat),
		.res_valid (res_valid),
		.res       (res)
	);

	assign last_valid = res_valid && en;
	assign out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= skid_full_q || last_valid;
			skid_full_q <= 1'b0;
		end else if (last_valid) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_full_q) begin
				out_res_q <= skid_res_q;
			end else if (last_valid) begin
				out_res_q <= res;
			end
		end else if (last_valid) begin
			skid_res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign jitter_x  = $signed(out_res_q.jx);
	assign jitter_y  = $signed(out_res_q.jy);

endmodule
`default_nettype wire

>>> rtl/hj23_checker.sv
// Port-level checker for the jitter core, bound to the top level.
`default_nettype none
module hj23_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic [hj23_pkg::JIT_W-1:0]     jitter_x,
	input wire logic [hj23_pkg::JIT_W-1:0]     jitter_y,
	input wire logic                           cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(jitter_x) && $stable(jitter_y))
		else $error("output payload changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without a stalled output beat");

	a_stall_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |=> !in_stall)
		else $error("input still stalled after output drained");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config channel not ready");

endmodule

bind halton_jitter_2_3_core hj23_checker u_hj23_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.jitter_x  (jitter_x),
	.jitter_y  (jitter_y),
	.cfg_ready (cfg_ready)
);
`default_nettype wire
